// ===== rtl/ivm_pkg.sv =====
// Shared types and widths for the inverse-variance merge core.
package ivm_pkg;

	localparam int VAL_W   = 32;  // signed value
	localparam int ERR_W   = 31;  // unsigned error
	localparam int SQ_W    = 62;  // squared error
	localparam int MAG_W   = 33;  // |v2 - v1|
	localparam int DEN_W   = 63;  // s1 + s2
	localparam int NUM_W   = 124; // widest dividend
	localparam int Q_W     = 62;  // quotient bits per divider
	localparam int ROOT_W  = 31;  // square-root result
	localparam int IN_W    = 128;
	localparam int OUT_W   = 64;
	localparam int FIFO_D  = 4;
	localparam int FIFO_AW = 2;

	// item handed from front to back
	typedef struct packed {
		logic              weighted;
		logic              neg;
		logic [VAL_W-1:0]  v1;
		logic [MAG_W-1:0]  mag;
		logic [SQ_W-1:0]   s1;
		logic [SQ_W-1:0]   s2;
	} ivm_work_t;

	// queue status seen by the front
	typedef struct packed {
		logic full;
		logic empty;
	} ivm_qstat_t;

endpackage

// ===== rtl/ivm_front.sv =====
// Front: input register, zero-error classification and squaring.
module ivm_front import ivm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [IN_W-1:0] in_data,
	input  ivm_qstat_t      qstat,
	output logic            push,
	output ivm_work_t       work
);

	logic             v_s1;
	logic [VAL_W-1:0] v1_s1, v2_s1;
	logic [ERR_W-1:0] e1_s1, e2_s1;
	logic [MAG_W-1:0] d;

	assign in_ready = !v_s1 || !qstat.full;
	assign push     = v_s1 && !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			v1_s1 <= in_data[31:0];
			e1_s1 <= in_data[62:32];
			v2_s1 <= in_data[94:63];
			e2_s1 <= in_data[125:95];
		end
	end

	always_comb begin
		d             = {v2_s1[VAL_W-1], v2_s1} - {v1_s1[VAL_W-1], v1_s1};
		work.weighted = (e1_s1 != '0) && (e2_s1 != '0);
		work.neg      = d[MAG_W-1];
		work.v1       = v1_s1;
		work.mag      = d[MAG_W-1] ? (~d + MAG_W'(1)) : d;
		work.s1       = SQ_W'(e1_s1) * SQ_W'(e1_s1);
		work.s2       = SQ_W'(e2_s1) * SQ_W'(e2_s1);
	end

endmodule

// ===== rtl/ivm_fifo.sv =====
// Short queue between front and back.
module ivm_fifo import ivm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ivm_work_t  wdata,
	input  logic       pop,
	output ivm_work_t  rdata,
	output ivm_qstat_t qstat
);

	ivm_work_t          mem_q [FIFO_D];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_AW:0]   cnt_q;

	assign qstat.full  = (cnt_q == (FIFO_AW+1)'(FIFO_D));
	assign qstat.empty = (cnt_q == '0);
	assign rdata       = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

endmodule

// ===== rtl/ivm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ivm_div #(
	parameter int NUM_W  = 124,
	parameter int DEN_W  = 63,
	parameter int Q_W    = 62,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vin,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              vout,
	output logic [Q_W-1:0]    quo,
	output logic [DEN_W-1:0]  rem,
	output logic [DEN_W-1:0]  den_out,
	output logic [SIDE_W-1:0] side_out
);

	logic [DEN_W-1:0]  r_q  [Q_W];
	logic [Q_W-1:0]    lo_q [Q_W];
	logic [Q_W-1:0]    qt_q [Q_W];
	logic [DEN_W-1:0]  dn_q [Q_W];
	logic [SIDE_W-1:0] sd_q [Q_W];
	logic [Q_W-1:0]    v_q;

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [DEN_W-1:0]  r_p, dn_p;
		logic [Q_W-1:0]    lo_p, qt_p;
		logic [SIDE_W-1:0] sd_p;
		logic              v_p;
		logic [DEN_W:0]    t;
		logic              ge;

		if (k == 0) begin : g_first
			assign r_p  = DEN_W'(num[NUM_W-1:Q_W]);
			assign lo_p = num[Q_W-1:0];
			assign qt_p = '0;
			assign dn_p = den;
			assign sd_p = side;
			assign v_p  = vin;
		end else begin : g_next
			assign r_p  = r_q[k-1];
			assign lo_p = lo_q[k-1];
			assign qt_p = qt_q[k-1];
			assign dn_p = dn_q[k-1];
			assign sd_p = sd_q[k-1];
			assign v_p  = v_q[k-1];
		end

		assign t  = {r_p, lo_p[Q_W-1]};
		assign ge = (t >= {1'b0, dn_p});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_q[k]  <= ge ? DEN_W'(t - {1'b0, dn_p}) : t[DEN_W-1:0];
				lo_q[k] <= {lo_p[Q_W-2:0], 1'b0};
				qt_q[k] <= {qt_p[Q_W-2:0], ge};
				dn_q[k] <= dn_p;
				sd_q[k] <= sd_p;
			end
		end
	end

	assign vout     = v_q[Q_W-1];
	assign quo      = qt_q[Q_W-1];
	assign rem      = r_q[Q_W-1];
	assign den_out  = dn_q[Q_W-1];
	assign side_out = sd_q[Q_W-1];

endmodule

// ===== rtl/ivm_back.sv =====
// Back: partial products, two dividers, rounding and pipelined square root.
module ivm_back import ivm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ivm_work_t        work,
	input  ivm_qstat_t       qstat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [VAL_W-1:0] out_value,
	output logic [ERR_W-1:0] out_error,
	output logic             out_weighted
);

	logic en;

	// stage 1: partial products
	logic             v_b1, w_b1, n_b1;
	logic [VAL_W-1:0] v1_b1;
	logic [63:0]      pm0_b1, pm1_b1;
	logic [61:0]      pll_b1, plh_b1, phl_b1, phh_b1;
	logic [DEN_W-1:0] sum_b1;

	// stage 2: full dividends
	logic             v_b2, w_b2, n_b2;
	logic [VAL_W-1:0] v1_b2;
	logic [NUM_W-1:0] nm_b2, ne_b2;
	logic [DEN_W-1:0] sum_b2;

	// divider outputs
	logic                   vm, ve, we;
	logic [Q_W-1:0]         qm, qe;
	logic [DEN_W-1:0]       rm, re, dm, de;
	logic [VAL_W:0]         sm;

	// stage 3: rounded mean, root input
	logic             v_b3, w_b3;
	logic [VAL_W-1:0] mean_b3;
	logic [Q_W-1:0]   x_b3;
	logic [VAL_W-1:0] qr;
	logic [DEN_W:0]   twice;
	logic             rnd;

	// root stages
	logic [ROOT_W-1:0] rt_q [ROOT_W];
	logic [ROOT_W+1:0] rr_q [ROOT_W];
	logic [Q_W-1:0]    xs_q [ROOT_W];
	logic [VAL_W-1:0]  mn_q [ROOT_W];
	logic [ROOT_W-1:0] sw_q;
	logic [ROOT_W-1:0] sv_q;

	assign en  = !out_valid || out_ready;
	assign pop = en && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
		end else if (en) begin
			v_b1 <= !qstat.empty;
			v_b2 <= v_b1;
			v_b3 <= vm && ve;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_b1   <= work.weighted;
			n_b1   <= work.neg;
			v1_b1  <= work.v1;
			pm0_b1 <= work.mag * work.s1[30:0];
			pm1_b1 <= work.mag * work.s1[61:31];
			pll_b1 <= work.s1[30:0] * work.s2[30:0];
			plh_b1 <= work.s1[30:0] * work.s2[61:31];
			phl_b1 <= work.s1[61:31] * work.s2[30:0];
			phh_b1 <= work.s1[61:31] * work.s2[61:31];
			sum_b1 <= {1'b0, work.s1} + {1'b0, work.s2};

			w_b2   <= w_b1;
			n_b2   <= n_b1;
			v1_b2  <= v1_b1;
			sum_b2 <= sum_b1;
			nm_b2  <= NUM_W'(pm0_b1) + (NUM_W'(pm1_b1) << 31);
			ne_b2  <= NUM_W'(pll_b1) + ((NUM_W'(plh_b1) + NUM_W'(phl_b1)) << 31)
				+ (NUM_W'(phh_b1) << 62);
		end
	end

	ivm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W), .SIDE_W(VAL_W+1)) u_div_mean (
		.clk, .arst_n, .en,
		.vin(v_b2), .num(nm_b2), .den(sum_b2), .side({n_b2, v1_b2}),
		.vout(vm), .quo(qm), .rem(rm), .den_out(dm), .side_out(sm)
	);

	ivm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W), .SIDE_W(1)) u_div_err (
		.clk, .arst_n, .en,
		.vin(v_b2), .num(ne_b2), .den(sum_b2), .side(w_b2),
		.vout(ve), .quo(qe), .rem(re), .den_out(de), .side_out(we)
	);

	// halves round up: toward the larger magnitude for a rising step only
	always_comb begin
		twice = {rm, 1'b0};
		rnd   = sm[VAL_W] ? (twice > {1'b0, dm}) : (twice >= {1'b0, dm});
		qr    = qm[VAL_W-1:0] + VAL_W'(rnd);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_b3    <= we && (re <= de);
			mean_b3 <= !we ? '0 : sm[VAL_W] ? (sm[VAL_W-1:0] - qr) : (sm[VAL_W-1:0] + qr);
			x_b3    <= qe;
		end
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		logic [ROOT_W-1:0] rt_p;
		logic [ROOT_W+1:0] rr_p;
		logic [Q_W-1:0]    xs_p;
		logic [VAL_W-1:0]  mn_p;
		logic              w_p, v_p;
		logic [ROOT_W+3:0] t, trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rt_p = '0;
			assign rr_p = '0;
			assign xs_p = x_b3;
			assign mn_p = mean_b3;
			assign w_p  = w_b3;
			assign v_p  = v_b3;
		end else begin : g_next
			assign rt_p = rt_q[k-1];
			assign rr_p = rr_q[k-1];
			assign xs_p = xs_q[k-1];
			assign mn_p = mn_q[k-1];
			assign w_p  = sw_q[k-1];
			assign v_p  = sv_q[k-1];
		end

		assign t     = {rr_p, xs_p[Q_W-1:Q_W-2]};
		assign trial = (ROOT_W+4)'({rt_p, 2'b01});
		assign ge    = (t >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_q[k] <= 1'b0;
			end else if (en) begin
				sv_q[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rr_q[k] <= ge ? (ROOT_W+2)'(t - trial) : t[ROOT_W+1:0];
				rt_q[k] <= {rt_p[ROOT_W-2:0], ge};
				xs_q[k] <= {xs_p[Q_W-3:0], 2'b00};
				mn_q[k] <= mn_p;
				sw_q[k] <= w_p;
			end
		end
	end

	assign out_valid    = sv_q[ROOT_W-1];
	assign out_weighted = sw_q[ROOT_W-1];
	assign out_value    = mn_q[ROOT_W-1];
	assign out_error    = sw_q[ROOT_W-1] ? rt_q[ROOT_W-1] : '0;

endmodule

// ===== rtl/inverse_variance_merge_core.sv =====
// Top level of the inverse-variance weighted merge of two measurements.
//
//  channel  dir  handshake                      content
//  s_axis   in   s_axis_tvalid/s_axis_tready    two values and two errors
//  m_axis   out  m_axis_tvalid/m_axis_tready    merged value, merged error, weight flag
//
// One item per cycle sustained while m_axis is not stalled. An accepted item passes
// through the input register, queue, two product stages, 62 divider stages
// (one quotient bit each), rounding, 31 root stages (one result bit each).
// arst_n clears all valid bits and the queue; payload registers are not reset.
// A stall on m_axis freezes the back pipeline; the front keeps accepting until
// its four-entry queue fills.
module inverse_variance_merge_core import ivm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// [31:0] first_value, [62:32] first_error, [94:63] second_value,
	// [125:95] second_error, [127:126] zero
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [31:0] merged_value, [62:32] merged_error, [63] zero
	output logic [OUT_W-1:0] m_axis_tdata,
	// [0] both_weighted
	output logic [0:0]       m_axis_tuser
);

	ivm_work_t  fr_work, q_work;
	ivm_qstat_t qstat;
	logic       push, pop;
	logic [VAL_W-1:0] value;
	logic [ERR_W-1:0] error;
	logic             weighted;

	ivm_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
		.qstat, .push, .work(fr_work)
	);

	ivm_fifo u_fifo (
		.clk, .arst_n,
		.push, .wdata(fr_work), .pop, .rdata(q_work), .qstat
	);

	ivm_back u_back (
		.clk, .arst_n,
		.work(q_work), .qstat, .pop,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_value(value), .out_error(error), .out_weighted(weighted)
	);

	assign m_axis_tdata = {1'b0, error, value};
	assign m_axis_tuser = weighted;

endmodule

// ===== rtl/ivm_checker.sv =====
// Port checker for the merge core, bound to the top level.
module ivm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("m_axis_tvalid dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("m_axis payload changed under stall");

	a_unweighted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
		else $error("unweighted item carries nonzero result");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("m_axis_tvalid high in reset");

endmodule

bind inverse_variance_merge_core ivm_checker u_ivm_checker (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

// ===== tb/inverse_variance_merge_core_tb.sv =====
// Self-checking testbench for the inverse-variance weighted merge core.
module inverse_variance_merge_core_tb;
	import ivm_pkg::*;

	typedef struct packed {
		logic             weighted;
		logic [ERR_W-1:0] err;
		logic [VAL_W-1:0] mean;
	} merge_res_t;

	typedef struct {
		logic [VAL_W-1:0] v1;
		logic [ERR_W-1:0] e1;
		logic [VAL_W-1:0] v2;
		logic [ERR_W-1:0] e2;
		bit               known;
		merge_res_t       res;
	} bin_row_t;

	localparam int LATENCY = 97;
	localparam int N_RANDOM = 1300;
	localparam longint CYCLE_LIMIT = 400000;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [0:0]       m_axis_tuser;

	merge_res_t merge_q[$];
	int         fails;
	int         n_sent;
	int         n_got;
	int         n_zero;
	longint     cycles;
	int         src_idle_pct;
	int         snk_idle_pct;

	inverse_variance_merge_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Weighted mean and combined error, exact wide arithmetic.
	function automatic merge_res_t merge_bins(logic [VAL_W-1:0] v1, logic [ERR_W-1:0] e1,
		logic [VAL_W-1:0] v2, logic [ERR_W-1:0] e2);
		merge_res_t r;
		logic [63:0]  s1, s2, tot, rem, quo, rt, x, bt;
		logic [127:0] num;
		logic signed [63:0] sv1, sv2, dif, mn;
		logic [63:0]  mag;
		r = '0;
		if (e1 == 0 || e2 == 0)
			return r;
		s1 = 64'(e1) * 64'(e1);
		s2 = 64'(e2) * 64'(e2);
		tot = s1 + s2;
		sv1 = 64'(signed'(v1));
		sv2 = 64'(signed'(v2));
		dif = sv2 - sv1;
		mag = dif < 0 ? 64'(-dif) : 64'(dif);
		num = 128'(mag) * 128'(s1);
		quo = 64'(num / 128'(tot));
		rem = 64'(num % 128'(tot));
		if (dif >= 0) begin
			if (2 * rem >= tot)
				quo++;
			mn = sv1 + signed'(quo);
		end else begin
			if (2 * rem > tot)
				quo++;
			mn = sv1 - signed'(quo);
		end
		num = 128'(s1) * 128'(s2);
		x = 64'(num / 128'(tot));
		rt = 0;
		bt = 64'd1 << 62;
		while (bt > x)
			bt >>= 2;
		while (bt != 0) begin
			if (x >= rt + bt) begin
				x -= rt + bt;
				rt = (rt >> 1) + bt;
			end else begin
				rt >>= 1;
			end
			bt >>= 2;
		end
		r.mean = mn[VAL_W-1:0];
		r.err = rt[ERR_W-1:0];
		r.weighted = 1'b1;
		return r;
	endfunction

	// Result checker and receiver stall.
	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (m_axis_tvalid && m_axis_tready) begin
				merge_res_t exp_r;
				n_got <= n_got + 1;
				if (merge_q.size() == 0) begin
					$error("unexpected result %h", m_axis_tdata);
					fails++;
				end else begin
					exp_r = merge_q.pop_front();
					if (m_axis_tdata[31:0] !== exp_r.mean) begin
						$error("merged_value exp %h got %h", exp_r.mean, m_axis_tdata[31:0]);
						fails++;
					end
					if (m_axis_tdata[62:32] !== exp_r.err) begin
						$error("merged_error exp %h got %h", exp_r.err, m_axis_tdata[62:32]);
						fails++;
					end
					if (m_axis_tuser[0] !== exp_r.weighted) begin
						$error("both_weighted exp %b got %b", exp_r.weighted, m_axis_tuser[0]);
						fails++;
					end
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	always @(negedge clk)
		if (arst_n)
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);

	task automatic send_bin(logic [VAL_W-1:0] v1, logic [ERR_W-1:0] e1,
		logic [VAL_W-1:0] v2, logic [ERR_W-1:0] e2, bit known, merge_res_t res);
		merge_res_t p;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {2'b00, e2, v2, e1, v1};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		p = merge_bins(v1, e1, v2, e2);
		if (known && p !== res) begin
			$error("predictor row exp %h got %h", res, p);
			fails++;
		end
		merge_q.push_back(p);
		n_sent++;
		if (!p.weighted)
			n_zero++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'(signed'($urandom_range(2000)) - 1000);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [ERR_W-1:0] rand_err();
		case ($urandom_range(9))
			0: return '0;
			1: return 31'h7FFF_FFFF;
			2: return 31'($urandom_range(1, 3));
			3: return 31'($urandom_range(1, 1 << 20));
			default: return 31'($urandom());
		endcase
	endfunction

	bin_row_t dir_rows[$];

	initial begin
		merge_res_t z;
		bin_row_t row;
		z = '0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		fails = 0; n_sent = 0; n_got = 0; n_zero = 0; cycles = 0;
		src_idle_pct = 15;
		snk_idle_pct = 82;

		// v1, e1, v2, e2, known, expected {weighted, err, mean}
		dir_rows = '{
			'{32'h0001_0000, 31'd0, 32'h0002_0000, 31'h1_0000, 1, z},
			'{32'h0001_0000, 31'h1_0000, 32'h0002_0000, 31'd0, 1, z},
			'{32'h7FFF_FFFF, 31'd0, 32'h8000_0000, 31'd0, 1, z},
			'{32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1, 1, {1'b1, 31'd0, 32'h7FFF_FFFF}},
			'{32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1, 1, {1'b1, 31'd0, 32'h8000_0000}},
			'{32'd0, 31'h7FFF_FFFF, 32'd0, 31'h7FFF_FFFF, 1, {1'b1, 31'h5A82_7999, 32'd0}},
			'{32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 0, z},
			'{32'h8000_0000, 31'd1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, z},
			'{32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'd1, 0, z},
			'{32'd1, 31'd1, 32'd2, 31'd1, 0, z},   // exact half, positive step
			'{32'd2, 31'd1, 32'd1, 31'd1, 0, z},   // exact half, negative step
			'{32'hFFFF_FFFF, 31'd1, 32'hFFFF_FFFE, 31'd1, 0, z},
			'{32'h0003_0000, 31'h1_0000, 32'h0001_0000, 31'h2_0000, 0, z},
			'{32'hFFFD_0000, 31'h3_0000, 32'h0005_0000, 31'h4_0000, 0, z},
			'{32'h1234_5678, 31'h5555_5555, 32'hEDCB_A987, 31'h2AAA_AAAA, 0, z}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_bin(row.v1, row.e1, row.v2, row.e2, row.known, row.res);
		end

		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 82 : 0;
			snk_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 15 : 0;
			for (int k = 0; k < N_RANDOM / 3; k++) begin
				send_bin(rand_word(), rand_err(), rand_word(), rand_err(), 0, z);
				// one full drain midway through the first phase
				if (ph == 0 && k == 200) begin
					s_axis_tvalid <= 1'b0;
					while (merge_q.size() != 0)
						@(negedge clk);
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		while (merge_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);

		$display("sent %0d bins (%0d with a zero error), checked %0d merged results",
			n_sent, n_zero, n_got);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ivm_pkg.sv
rtl/ivm_front.sv
rtl/ivm_fifo.sv
rtl/ivm_div.sv
rtl/ivm_back.sv
rtl/inverse_variance_merge_core.sv
rtl/ivm_checker.sv
tb/inverse_variance_merge_core_tb.sv
